// ----- hw/rtl/amicable_pair_sum_top_assert.svh -----
// Assertion macros used by the amicable pair sum top level.
`ifndef AMICABLE_PAIR_SUM_TOP_ASSERT_SVH
`define AMICABLE_PAIR_SUM_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define APS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("amicable_pair_sum: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define APS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("amicable_pair_sum: next-cycle check failed");

`endif

// ----- hw/rtl/apsum_pkg.sv -----
// Package with the types, constants and microcode ROM of the amicable pair sum block.
`default_nettype none

package apsum_pkg;

    localparam int MAX_RANGE_DEF = 4096;
    localparam int LIMIT_W       = 13;
    localparam int TOTAL_W       = 25;
    localparam int UPC_W         = 4;

    typedef logic [UPC_W-1:0] t_upc;

    // Microprogram step addresses.
    localparam t_upc S_IDLE      = 4'd0;
    localparam t_upc S_INIT_CHK  = 4'd1;
    localparam t_upc S_INIT_WR   = 4'd2;
    localparam t_upc S_SIEVE_D0  = 4'd3;
    localparam t_upc S_SIEVE_D   = 4'd4;
    localparam t_upc S_SIEVE_RD  = 4'd5;
    localparam t_upc S_SIEVE_WR  = 4'd6;
    localparam t_upc S_SIEVE_NXT = 4'd7;
    localparam t_upc S_PAIR_0    = 4'd8;
    localparam t_upc S_PAIR_RD   = 4'd9;
    localparam t_upc S_PAIR_S    = 4'd10;
    localparam t_upc S_PAIR_CHK  = 4'd11;
    localparam t_upc S_PAIR_ADD  = 4'd12;
    localparam t_upc S_PAIR_NXT  = 4'd13;
    localparam t_upc S_DONE      = 4'd14;

    typedef enum logic [2:0] {
        C_NEXT       = 3'd0,
        C_ALWAYS     = 3'd1,
        C_NO_START   = 3'd2,
        C_I_GT_N     = 3'd3,
        C_TWO_I_GT_N = 3'd4,
        C_K_GT_N     = 3'd5,
        C_S_BAD      = 3'd6
    } t_cond;

    typedef enum logic [1:0] {
        I_HOLD = 2'd0,
        I_ONE  = 2'd1,
        I_INC  = 2'd2
    } t_iop;

    typedef enum logic [1:0] {
        K_HOLD   = 2'd0,
        K_DOUBLE = 2'd1,
        K_STEP   = 2'd2
    } t_kop;

    typedef enum logic [1:0] {
        W_NONE = 2'd0,
        W_INIT = 2'd1,
        W_ADD  = 2'd2
    } t_wop;

    typedef enum logic [1:0] {
        R_I = 2'd0,
        R_K = 2'd1,
        R_S = 2'd2
    } t_rsel;

    typedef enum logic [1:0] {
        T_HOLD      = 2'd0,
        T_CLEAR     = 2'd1,
        T_ADD_MATCH = 2'd2
    } t_top;

    typedef struct packed {
        t_cond cond;
        t_upc  target;
        logic  idle;
        logic  ld_lim;
        t_iop  i_op;
        t_kop  k_op;
        t_wop  w_op;
        t_rsel r_sel;
        logic  s_ld;
        t_top  t_op;
        logic  strobe;
    } t_cw;

    typedef struct packed {
        logic i_gt_n;
        logic two_i_gt_n;
        logic k_gt_n;
        logic s_bad;
    } t_flags;

    // Microprogram: one control word per step. A word whose condition holds
    // jumps to its target, otherwise the step counter advances by one.
    function automatic t_cw uc_rom(input t_upc upc);
        t_cw cw;
        cw = '0;
        case (upc)
            S_IDLE: begin
                cw.idle   = 1'b1;
                cw.ld_lim = 1'b1;
                cw.i_op   = I_ONE;
                cw.t_op   = T_CLEAR;
                cw.cond   = C_NO_START;
                cw.target = S_IDLE;
            end
            S_INIT_CHK: begin
                cw.cond   = C_I_GT_N;
                cw.target = S_SIEVE_D0;
            end
            S_INIT_WR: begin
                cw.w_op   = W_INIT;
                cw.i_op   = I_INC;
                cw.cond   = C_ALWAYS;
                cw.target = S_INIT_CHK;
            end
            S_SIEVE_D0: begin
                cw.i_op = I_ONE;
            end
            S_SIEVE_D: begin
                cw.k_op   = K_DOUBLE;
                cw.cond   = C_TWO_I_GT_N;
                cw.target = S_PAIR_0;
            end
            S_SIEVE_RD: begin
                cw.r_sel  = R_K;
                cw.cond   = C_K_GT_N;
                cw.target = S_SIEVE_NXT;
            end
            S_SIEVE_WR: begin
                cw.r_sel  = R_K;
                cw.w_op   = W_ADD;
                cw.k_op   = K_STEP;
                cw.cond   = C_ALWAYS;
                cw.target = S_SIEVE_RD;
            end
            S_SIEVE_NXT: begin
                cw.i_op   = I_INC;
                cw.cond   = C_ALWAYS;
                cw.target = S_SIEVE_D;
            end
            S_PAIR_0: begin
                cw.i_op = I_ONE;
            end
            S_PAIR_RD: begin
                cw.r_sel  = R_I;
                cw.cond   = C_I_GT_N;
                cw.target = S_DONE;
            end
            S_PAIR_S: begin
                cw.s_ld = 1'b1;
            end
            S_PAIR_CHK: begin
                cw.r_sel  = R_S;
                cw.cond   = C_S_BAD;
                cw.target = S_PAIR_NXT;
            end
            S_PAIR_ADD: begin
                cw.t_op = T_ADD_MATCH;
            end
            S_PAIR_NXT: begin
                cw.i_op   = I_INC;
                cw.cond   = C_ALWAYS;
                cw.target = S_PAIR_RD;
            end
            S_DONE: begin
                cw.strobe = 1'b1;
                cw.cond   = C_ALWAYS;
                cw.target = S_IDLE;
            end
            default: begin
                cw.cond   = C_ALWAYS;
                cw.target = S_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/apsum_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module apsum_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/apsum_seq.sv -----
// Microcode sequencer: step counter, control word ROM and conditional jumps.
`default_nettype none

module apsum_seq
    import apsum_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_flags i_flags,
    output t_cw         o_cw
);

    t_upc r_upc;
    t_upc n_upc;
    t_cw  cw;
    logic take;

    assign cw   = uc_rom(r_upc);
    assign o_cw = cw;

    always_comb begin
        case (cw.cond)
            C_NEXT:       take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NO_START:   take = !i_start;
            C_I_GT_N:     take = i_flags.i_gt_n;
            C_TWO_I_GT_N: take = i_flags.two_i_gt_n;
            C_K_GT_N:     take = i_flags.k_gt_n;
            C_S_BAD:      take = i_flags.s_bad;
            default:      take = 1'b1;
        endcase
        n_upc = take ? cw.target : t_upc'(r_upc + t_upc'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/apsum_dp.sv -----
// Datapath: index registers, divisor-sum table, comparators and the running total.
`default_nettype none

module apsum_dp
    import apsum_pkg::*;
#(
    parameter int MAX_RANGE = MAX_RANGE_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cw                 i_cw,
    input  wire logic [LIMIT_W-1:0]  i_range_limit,
    output t_flags                   o_flags,
    output logic      [TOTAL_W-1:0]  o_pair_total
);

    localparam int IW = $clog2(MAX_RANGE + 1);
    localparam int CW = IW + 1;
    localparam int SW = IW + 3;
    localparam int AW = $clog2(MAX_RANGE);

    logic [IW-1:0]      r_lim;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      n_idx;
    logic [CW-1:0]      r_k;
    logic [CW-1:0]      n_k;
    logic [SW-1:0]      r_s;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;

    logic [IW-1:0]      lim_sat;
    logic [CW-1:0]      idx_m1;
    logic [CW-1:0]      k_m1;
    logic [SW-1:0]      s_m1;
    logic [SW-1:0]      rd_data;
    logic [SW-1:0]      wr_data;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic               match;

    // Limits above the table size saturate.
    assign lim_sat = (32'(i_range_limit) > 32'(MAX_RANGE)) ? IW'(MAX_RANGE)
                                                           : IW'(i_range_limit);

    assign idx_m1 = r_idx - CW'(1);
    assign k_m1   = r_k - CW'(1);
    assign s_m1   = r_s - SW'(1);
    assign match  = (rd_data == SW'(r_idx));

    assign o_flags.i_gt_n     = (r_idx > CW'(r_lim));
    assign o_flags.two_i_gt_n = ({r_idx, 1'b0} > (CW + 1)'(r_lim));
    assign o_flags.k_gt_n     = (r_k > CW'(r_lim));
    assign o_flags.s_bad      = !((r_s > SW'(r_idx)) && (r_s <= SW'(r_lim)));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_m1[AW-1:0];
        wr_data = '0;
        case (i_cw.w_op)
            W_NONE: begin
                wr_en = 1'b0;
            end
            W_INIT: begin
                wr_en   = 1'b1;
                wr_data = (r_idx == CW'(1)) ? SW'(1) : '0;
            end
            W_ADD: begin
                wr_en   = 1'b1;
                wr_addr = k_m1[AW-1:0];
                wr_data = rd_data + SW'(r_idx);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (i_cw.r_sel)
            R_I:     rd_addr = idx_m1[AW-1:0];
            R_K:     rd_addr = k_m1[AW-1:0];
            R_S:     rd_addr = s_m1[AW-1:0];
            default: rd_addr = idx_m1[AW-1:0];
        endcase
    end

    always_comb begin
        case (i_cw.i_op)
            I_HOLD:  n_idx = r_idx;
            I_ONE:   n_idx = CW'(1);
            I_INC:   n_idx = r_idx + CW'(1);
            default: n_idx = r_idx;
        endcase
        case (i_cw.k_op)
            K_HOLD:   n_k = r_k;
            K_DOUBLE: n_k = {r_idx[CW-2:0], 1'b0};
            K_STEP:   n_k = r_k + r_idx;
            default:  n_k = r_k;
        endcase
        case (i_cw.t_op)
            T_HOLD:      n_total = r_total;
            T_CLEAR:     n_total = '0;
            T_ADD_MATCH: n_total = match ? (r_total + TOTAL_W'(r_idx) + TOTAL_W'(r_s))
                                         : r_total;
            default:     n_total = r_total;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else begin
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_k   <= n_k;
        if (i_cw.ld_lim) begin
            r_lim <= lim_sat;
        end
        if (i_cw.s_ld) begin
            r_s <= rd_data;
        end
    end

    apsum_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_RANGE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign o_pair_total = r_total;

endmodule

`default_nettype wire

// ----- hw/rtl/amicable_pair_sum_top.sv -----
// Top level of the amicable pair sum block: sequencer and datapath.
`default_nettype none
`include "amicable_pair_sum_top_assert.svh"

// Amicable pair sum. A transaction starts at a rising edge at which start is
// high and busy is low; i_range_limit gives n, and values above MAX_RANGE are
// treated as MAX_RANGE. The block then raises busy and works through three
// passes driven by a microprogram: it initialises the divisor-sum table for
// 1..n, sieves every d with 2d <= n into its multiples with a read and a
// write of the table per multiple, and finally walks 1..n, checking each
// candidate partner in the table. When it finishes, o_valid is high for
// exactly one cycle with the sum of all members of amicable pairs in 1..n on
// o_pair_total; the receiver cannot hold this result off, so it must take it
// in that cycle. Busy falls in the following cycle. The run time is set by
// the single table port pair, which the sieve pass uses twice per multiple.
// No clearing pass follows reset, since every table entry whose value is
// used has been written earlier in the same transaction.
module amicable_pair_sum_top
    import apsum_pkg::*;
#(
    parameter int MAX_RANGE = MAX_RANGE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [LIMIT_W-1:0] i_range_limit,
    output logic                    o_valid,
    output logic      [TOTAL_W-1:0] o_pair_total
);

    t_cw    cw;
    t_flags flags;

    // The sequencer owns all control; the datapath only reports comparisons.
    apsum_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (flags),
        .o_cw    (cw)
    );

    apsum_dp #(
        .MAX_RANGE (MAX_RANGE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cw          (cw),
        .i_range_limit (i_range_limit),
        .o_flags       (flags),
        .o_pair_total  (o_pair_total)
    );

    // Busy is low only in the idle step, which is where start is sampled.
    assign busy    = !cw.idle;
    assign o_valid = cw.strobe;

    // An accepted transaction moves the block out of idle.
    `APS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // The result strobe lasts exactly one cycle.
    `APS_ASSERT_NEXT(a_strobe_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    // After the result the block returns to idle.
    `APS_ASSERT_NEXT(a_strobe_idle, i_clk, i_rst_n, o_valid, !busy)
    // No result appears while the block is idle.
    `APS_ASSERT_NOW(a_idle_quiet, i_clk, i_rst_n, !busy, !o_valid)

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the amicable pair sum block.
`timescale 1ns / 1ps

module tb_top
    import apsum_pkg::*;
();

    // A directed row holds a range limit and, where the answer is obvious, the
    // total typed in by hand. Rows without a typed total go to the predictor.
    typedef struct packed {
        logic [LIMIT_W-1:0] limit;
        logic               typed;
        logic [TOTAL_W-1:0] total;
    } t_limit_row;

    // What the sender knows about a transaction it has put on the inputs.
    typedef struct packed {
        logic               typed;
        logic [TOTAL_W-1:0] total;
    } t_limit_request;

    // Run ceiling in nanoseconds.
    localparam longint RUN_CEILING_NS = 400000000;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic [LIMIT_W-1:0] i_range_limit = '0;
    logic               busy;
    logic               o_valid;
    logic [TOTAL_W-1:0] o_pair_total;

    // Divisor sums s(v) for every v in the searchable range. They do not
    // depend on the limit, so the table is filled once before the stimulus.
    logic [15:0]        divisor_sums [1:MAX_RANGE_DEF];

    t_limit_request     limit_requests [$];
    logic [TOTAL_W-1:0] expected_totals [$];
    int                 error_count;
    int                 idle_pct;

    // The directed part. The zero limit gives an empty range. The limit just
    // below and at the larger member of the first and third pairs shows that
    // a pair only counts once both members lie in range. Perfect numbers have
    // s(v) equal to v and must never contribute. The top row checks saturation.
    t_limit_row directed_rows [18] = '{
        '{13'd0,    1'b1, 25'd0},
        '{13'd1,    1'b1, 25'd0},
        '{13'd2,    1'b0, 25'd0},
        '{13'd6,    1'b0, 25'd0},
        '{13'd28,   1'b0, 25'd0},
        '{13'd219,  1'b0, 25'd0},
        '{13'd220,  1'b0, 25'd0},
        '{13'd283,  1'b0, 25'd0},
        '{13'd284,  1'b1, 25'd504},
        '{13'd285,  1'b0, 25'd0},
        '{13'd496,  1'b0, 25'd0},
        '{13'd1184, 1'b0, 25'd0},
        '{13'd1210, 1'b1, 25'd2898},
        '{13'd2923, 1'b0, 25'd0},
        '{13'd2924, 1'b1, 25'd8442},
        '{13'd4096, 1'b1, 25'd8442},
        '{13'd8191, 1'b1, 25'd8442},
        '{13'd300,  1'b0, 25'd0}
    };

    amicable_pair_sum_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_range_limit(i_range_limit),
        .o_valid      (o_valid),
        .o_pair_total (o_pair_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // A generous ceiling: the slowest legitimate run, with every random limit
    // drawn at its largest and every sender gap at its longest, stays under a
    // fifth of this.
    initial begin
        #(RUN_CEILING_NS);
        $display("Verification failed");
        $finish;
    end

    // Predicted total for one transaction. The limit saturates at the table
    // size, and a pair is counted through its smaller member only, so each
    // pair adds both members exactly once.
    function automatic logic [TOTAL_W-1:0] amicable_total(input logic [LIMIT_W-1:0] limit);
        int unsigned        n;
        int unsigned        s;
        logic [TOTAL_W-1:0] total;
        n = (32'(limit) > 32'(MAX_RANGE_DEF)) ? 32'(MAX_RANGE_DEF) : 32'(limit);
        total = '0;
        for (int unsigned i = 1; i <= n; i++) begin
            s = 32'(divisor_sums[i]);
            if (s > i && s <= n && 32'(divisor_sums[s]) == i) begin
                total = total + TOTAL_W'(i) + TOTAL_W'(s);
            end
        end
        return total;
    endfunction

    task automatic report_mismatch(input string what, input logic [TOTAL_W-1:0] got,
                                   input logic [TOTAL_W-1:0] want);
        $display("MISMATCH at %0t ns: %s, got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Presents one range limit and holds it until the block takes it. While
    // waiting, start is dropped at random in idle_pct cycles of a hundred, so
    // gaps land both in the short idle window and during the block's work,
    // where a raised start must simply be ignored. Only one nonblocking write
    // of start happens per clock edge.
    task automatic issue_limit(input logic [LIMIT_W-1:0] limit, input logic typed,
                               input logic [TOTAL_W-1:0] total);
        logic accepted;
        limit_requests.push_back('{typed, total});
        i_range_limit <= limit;
        start         <= (int'($urandom_range(99)) >= idle_pct);
        accepted = 1'b0;
        while (!accepted) begin
            @(posedge i_clk);
            if (start && !busy) begin
                accepted = 1'b1;
            end else begin
                start <= (int'($urandom_range(99)) >= idle_pct);
            end
        end
    endtask

    // Acceptance and result checking share one process, sampling the values
    // that were stable before each rising edge. A transaction's expected total
    // is queued at the edge that accepts it; each strobed result is compared
    // with the oldest total still waiting.
    always @(posedge i_clk) begin
        t_limit_request     req;
        logic [TOTAL_W-1:0] want;
        if (i_rst_n) begin
            if (start && !busy) begin
                req = limit_requests.pop_front();
                expected_totals.push_back(req.typed ? req.total : amicable_total(i_range_limit));
            end
            if (o_valid) begin
                if (expected_totals.size() == 0) begin
                    report_mismatch("pair_total with no transaction outstanding",
                                    o_pair_total, '0);
                end else begin
                    want = expected_totals.pop_front();
                    if (o_pair_total !== want) begin
                        report_mismatch("pair_total", o_pair_total, want);
                    end
                end
            end
        end
    end

    initial begin
        int                 acc;
        int                 item;
        int                 pick;
        logic [LIMIT_W-1:0] limit;
        error_count = 0;
        idle_pct    = 24;
        item        = 0;

        for (int v = 1; v <= MAX_RANGE_DEF; v++) begin
            acc = 1;
            for (int d = 2; d * d <= v; d++) begin
                if (v % d == 0) begin
                    acc += d;
                    if (v / d != d) begin
                        acc += v / d;
                    end
                end
            end
            divisor_sums[v] = acc[15:0];
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The sender idles often in the first third, heavily in the second
        // and never in the last.
        foreach (directed_rows[r]) begin
            idle_pct = (item < 34) ? 24 : (item < 67) ? 77 : 0;
            issue_limit(directed_rows[r].limit, directed_rows[r].typed, directed_rows[r].total);
            item++;
        end

        // Run time grows with the limit, so most random limits stay small,
        // a good share reach the first pair, a few the second, and a single
        // one is drawn from the top of the range, where it may saturate.
        for (int k = 0; k < 82; k++) begin
            idle_pct = (item < 34) ? 24 : (item < 67) ? 77 : 0;
            pick = int'($urandom_range(99));
            if (k == 47) begin
                limit = LIMIT_W'($urandom_range(8191, 2000));
            end else if (pick < 62) begin
                limit = LIMIT_W'($urandom_range(320, 0));
            end else if (pick < 94) begin
                limit = LIMIT_W'($urandom_range(460, 270));
            end else begin
                limit = LIMIT_W'($urandom_range(1500, 460));
            end
            issue_limit(limit, 1'b0, '0);
            item++;
        end
        start <= 1'b0;

        while (expected_totals.size() != 0 || limit_requests.size() != 0) begin
            @(posedge i_clk);
        end
        // Keep clocking to catch a stray strobe after the last result.
        repeat (20) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
